@@ rtl/signed_radix_to_ascii_unit_assert.svh @@
// ----------------------------------------------------------------------------
// signed_radix_to_ascii_unit_assert.svh
// Assertion macros for the signed radix to ascii unit; empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef SIGNED_RADIX_TO_ASCII_UNIT_ASSERT_SVH
`define SIGNED_RADIX_TO_ASCII_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define SRTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked outside reset
`define SRTA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRTA_ASSERT_IMP(lbl, ante, cons, msg)
`define SRTA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/srta_pkg.sv @@
// ----------------------------------------------------------------------------
// srta_pkg
// Shared types and constants of the signed radix to ascii unit
// ----------------------------------------------------------------------------
`default_nettype none

package srta_pkg;

  // parameter defaults
  localparam int MAX_RADIX_DEF  = 16;
  localparam int VALUE_BITS_DEF = 32;

  // quotient bits resolved by the divider in one cycle
  localparam int DIV_BITS_PER_CYCLE = 4;

  // fixed field widths
  localparam int CHAR_W       = 8;
  localparam int ALPHA_CHARS  = 16;
  localparam int RADIX_LEN_W  = 5;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 2;
  localparam int IN_DATA_W    = 32;
  localparam int ALPHA_IDX_W  = 4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RADIX_LEN   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIGITS_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIGITS_HIGH = 2'd2;

  // characters
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_READ,
    ST_LOAD,
    ST_EMIT
  } state_t;

  // sequencer strobes to the datapath
  typedef struct packed {
    logic accept;
    logic chk_step;
    logic chk_fail;
    logic div_start;
    logic push;
    logic sign_load;
    logic pop;
    logic char_load;
    logic take;
  } ctl_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

@@ rtl/srta_div.sv @@
// ----------------------------------------------------------------------------
// srta_div
// Iterative restoring divider by a small radix, several quotient bits a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module srta_div #(
  parameter int DIV_W  = 32,
  parameter int DIG_W  = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIV_W-1:0]      dividend,
  input  wire logic [DIG_W:0]        divisor,
  output srta_pkg::div_stat_t        stat,
  output logic      [DIV_W-1:0]      quotient,
  output logic      [DIG_W-1:0]      remainder
);

  localparam int BPC    = srta_pkg::DIV_BITS_PER_CYCLE;
  localparam int STEPS  = DIV_W / BPC;
  localparam int STEP_W = $clog2(STEPS + 1);

  logic [STEP_W-1:0] step_cnt;
  logic              done;
  logic [DIV_W-1:0]  q_w;
  logic [DIG_W:0]    r_w;

  // BPC shift-compare-subtract steps; dividend bits leave at the top,
  // quotient bits enter at the bottom
  always_comb begin
    q_w = quotient;
    r_w = {1'b0, remainder};
    for (int k = 0; k < BPC; k++) begin
      r_w = {r_w[DIG_W-1:0], q_w[DIV_W-1]};
      q_w = {q_w[DIV_W-2:0], 1'b0};
      if (r_w >= divisor) begin
        r_w    = r_w - divisor;
        q_w[0] = 1'b1;
      end
    end
  end

  // step counter and done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step_cnt <= STEP_W'(STEPS);
      end else if (step_cnt != '0) begin
        step_cnt <= step_cnt - 1'b1;
        done     <= (step_cnt == STEP_W'(1));
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (step_cnt != '0) begin
      quotient  <= q_w;
      remainder <= r_w[DIG_W-1:0];
    end
  end

  assign stat.busy = (step_cnt != '0);
  assign stat.done = done;

endmodule

`default_nettype wire

@@ rtl/srta_stack.sv @@
// ----------------------------------------------------------------------------
// srta_stack
// Digit memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module srta_stack #(
  parameter int DEPTH  = 32,
  parameter int DATA_W = 4
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/srta_check.sv @@
// ----------------------------------------------------------------------------
// srta_check
// Checks one alphabet character against the sign characters and the rest
// ----------------------------------------------------------------------------
`default_nettype none

module srta_check (
  input  wire logic [srta_pkg::ALPHA_CHARS*srta_pkg::CHAR_W-1:0] alpha,
  input  wire logic [srta_pkg::RADIX_LEN_W-1:0]                  radix_len,
  input  wire logic [srta_pkg::ALPHA_IDX_W-1:0]                  idx,
  output logic                                                   bad
);

  localparam int CW = srta_pkg::CHAR_W;

  logic [CW-1:0] ch;

  assign ch = alpha[idx*CW +: CW];

  // sign characters, or the same character later in the alphabet in use
  always_comb begin
    bad = (ch == srta_pkg::CH_PLUS) || (ch == srta_pkg::CH_MINUS);
    for (int j = 0; j < srta_pkg::ALPHA_CHARS; j++) begin
      if ((srta_pkg::RADIX_LEN_W'(j) > {1'b0, idx}) &&
          (srta_pkg::RADIX_LEN_W'(j) < radix_len) &&
          (alpha[j*CW +: CW] == ch)) begin
        bad = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/signed_radix_to_ascii_unit.sv @@
// ----------------------------------------------------------------------------
// signed_radix_to_ascii_unit
// Writes a signed number as text in a radix set by a configured alphabet
// ----------------------------------------------------------------------------
//  channel  dir  signals                        payload
//  s_*      in   s_tvalid s_tready s_tdata[31:0] value
//  m_*      out  m_tvalid m_tready m_tdata[7:0]  out_char, m_tlast = last
//  cfg_*    in   cfg_we cfg_index[1:0] cfg_data  radix_len, digits_low/high
//
//  One request at a time. The shared divider resolves 4 quotient bits a cycle
//  for each digit, and each digit waits on a registered digit memory read
//  before it goes out. Radix 2 on the most negative value is the long case.
//  A bad length gives '0' straight from idle, a bad character once the
//  character-by-character check reaches it.
//  Synchronous reset returns to idle; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_radix_to_ascii_unit_assert.svh"

module signed_radix_to_ascii_unit #(
  parameter int MAX_RADIX  = srta_pkg::MAX_RADIX_DEF,
  parameter int VALUE_BITS = srta_pkg::VALUE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [srta_pkg::IN_DATA_W-1:0]     s_tdata,   // value
  // output stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [srta_pkg::CHAR_W-1:0]        m_tdata,   // out_char
  output logic                                    m_tlast,
  // configuration writes
  input  wire logic                               cfg_we,
  input  wire logic [srta_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [srta_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int BPC   = srta_pkg::DIV_BITS_PER_CYCLE;
  localparam int DIV_W = ((VALUE_BITS + BPC - 1) / BPC) * BPC;
  localparam int DIG_W = $clog2(MAX_RADIX);
  localparam int AW    = $clog2(VALUE_BITS);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int CW    = srta_pkg::CHAR_W;
  localparam int LW    = srta_pkg::RADIX_LEN_W;
  localparam int IW    = srta_pkg::ALPHA_IDX_W;

  // configuration registers
  logic [LW-1:0]                     radix_len;
  logic [srta_pkg::CFG_DATA_W-1:0]   digits_low;
  logic [srta_pkg::CFG_DATA_W-1:0]   digits_high;
  logic [2*srta_pkg::CFG_DATA_W-1:0] alpha;

  // sequencer and datapath
  srta_pkg::state_t    state;
  srta_pkg::state_t    state_next;
  srta_pkg::ctl_t      ctl;
  srta_pkg::div_stat_t div_stat;
  logic                neg;
  logic [DIV_W-1:0]    mag;
  logic [IW-1:0]       chk_idx;
  logic [CNT_W-1:0]    dcnt;
  logic [CNT_W-1:0]    dcnt_dec;
  logic                len_bad;
  logic                chk_bad;
  logic                chk_last;
  logic                raw_neg;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] raw_mag;
  logic [DIV_W-1:0]    div_quot;
  logic [DIG_W-1:0]    div_rem;
  logic [DIG_W-1:0]    rd_digit;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_len   <= '0;
      digits_low  <= '0;
      digits_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srta_pkg::REG_RADIX_LEN:   radix_len   <= cfg_data[LW-1:0];
        srta_pkg::REG_DIGITS_LOW:  digits_low  <= cfg_data;
        srta_pkg::REG_DIGITS_HIGH: digits_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign alpha = {digits_high, digits_low};

  // input decode: magnitude is exact in VALUE_BITS unsigned bits
  assign raw      = s_tdata[VALUE_BITS-1:0];
  assign raw_neg  = raw[VALUE_BITS-1];
  assign raw_mag  = raw_neg ? (~raw + 1'b1) : raw;
  assign len_bad  = (radix_len < LW'(2)) || (radix_len > LW'(MAX_RADIX));
  assign chk_last = (({1'b0, chk_idx} + LW'(1)) == radix_len);
  assign dcnt_dec = dcnt - 1'b1;

  // alphabet checker
  srta_check u_check (
    .alpha     (alpha),
    .radix_len (radix_len),
    .idx       (chk_idx),
    .bad       (chk_bad)
  );

  // shared divider
  srta_div #(
    .DIV_W (DIV_W),
    .DIG_W (DIG_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.div_start),
    .dividend  (mag),
    .divisor   (radix_len[DIG_W:0]),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // digit memory, last digit out first
  srta_stack #(
    .DEPTH  (VALUE_BITS),
    .DATA_W (DIG_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ctl.push),
    .wr_addr (dcnt[AW-1:0]),
    .wr_data (div_rem),
    .rd_en   (ctl.pop),
    .rd_addr (dcnt_dec[AW-1:0]),
    .rd_data (rd_digit)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      srta_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = len_bad ? srta_pkg::ST_EMIT : srta_pkg::ST_CHECK;
        end
      end
      srta_pkg::ST_CHECK: begin
        if (chk_bad) begin
          state_next = srta_pkg::ST_EMIT;
        end else if (chk_last) begin
          state_next = srta_pkg::ST_DIV_GO;
        end
      end
      srta_pkg::ST_DIV_GO: state_next = srta_pkg::ST_DIV_WAIT;
      srta_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = (div_quot == '0) ? srta_pkg::ST_SIGN : srta_pkg::ST_DIV_GO;
        end
      end
      srta_pkg::ST_SIGN: state_next = neg ? srta_pkg::ST_EMIT : srta_pkg::ST_READ;
      srta_pkg::ST_READ: state_next = srta_pkg::ST_LOAD;
      srta_pkg::ST_LOAD: state_next = srta_pkg::ST_EMIT;
      srta_pkg::ST_EMIT: begin
        if (m_tready) begin
          state_next = m_tlast ? srta_pkg::ST_IDLE : srta_pkg::ST_READ;
        end
      end
      default: state_next = srta_pkg::ST_IDLE;
    endcase
  end

  // sequencer strobes
  always_comb begin
    ctl      = '0;
    s_tready = 1'b0;
    unique case (state)
      srta_pkg::ST_IDLE: begin
        s_tready     = 1'b1;
        ctl.accept   = s_tvalid;
        ctl.chk_fail = s_tvalid && len_bad;
      end
      srta_pkg::ST_CHECK: begin
        ctl.chk_step = 1'b1;
        ctl.chk_fail = chk_bad;
      end
      srta_pkg::ST_DIV_GO:   ctl.div_start = 1'b1;
      srta_pkg::ST_DIV_WAIT: ctl.push      = div_stat.done;
      srta_pkg::ST_SIGN:     ctl.sign_load = neg;
      srta_pkg::ST_READ:     ctl.pop       = 1'b1;
      srta_pkg::ST_LOAD:     ctl.char_load = 1'b1;
      srta_pkg::ST_EMIT:     ctl.take      = m_tready;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= srta_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      chk_idx  <= '0;
      dcnt     <= '0;
    end else begin
      state <= state_next;
      if (ctl.accept) begin
        chk_idx <= '0;
        dcnt    <= '0;
      end
      if (ctl.chk_step) begin
        chk_idx <= chk_idx + 1'b1;
      end
      if (ctl.push) begin
        dcnt <= dcnt + 1'b1;
      end
      if (ctl.pop) begin
        dcnt <= dcnt_dec;
      end
      if (ctl.chk_fail || ctl.sign_load || ctl.char_load) begin
        m_tvalid <= 1'b1;
      end else if (ctl.take) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      neg <= raw_neg;
      mag <= DIV_W'(raw_mag);
    end
    if (ctl.push) begin
      mag <= div_quot;
    end
    if (ctl.chk_fail) begin
      m_tdata <= srta_pkg::CH_ZERO;
      m_tlast <= 1'b1;
    end else if (ctl.sign_load) begin
      m_tdata <= srta_pkg::CH_MINUS;
      m_tlast <= 1'b0;
    end else if (ctl.char_load) begin
      m_tdata <= alpha[IW'(rd_digit)*CW +: CW];
      m_tlast <= (dcnt == '0);
    end
  end

  // checks
  `SRTA_ASSERT_IMP(a_idle_no_out, s_tready, !m_tvalid, "request taken with output pending")
  `SRTA_ASSERT_IMP(a_last_empty, m_tvalid && m_tlast, dcnt == '0, "last char with digits left")
  `SRTA_ASSERT_IMP(a_div_free, ctl.div_start, !div_stat.busy, "divider restarted while busy")
  `SRTA_ASSERT_NXT(a_push_grows, ctl.push, dcnt != '0, "digit count did not grow on push")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream test of signed_radix_to_ascii_unit: converts signed values under
// many alphabets and checks every character and its last flag in order
// ----------------------------------------------------------------------------
module tb;

  localparam int CHAR_W        = srta_pkg::CHAR_W;
  localparam int RADIX_LEN_W   = srta_pkg::RADIX_LEN_W;
  localparam int CFG_DATA_W    = srta_pkg::CFG_DATA_W;
  localparam int CFG_INDEX_W   = srta_pkg::CFG_INDEX_W;
  localparam int IN_DATA_W     = srta_pkg::IN_DATA_W;
  localparam int ALPHA_CHARS   = srta_pkg::ALPHA_CHARS;
  localparam int MAX_RADIX_DEF = srta_pkg::MAX_RADIX_DEF;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 500;
  localparam int PHASES        = 14;
  localparam int PHASE_VALUES  = 13;

  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic              last;
  } text_char_t;

  typedef enum int {
    FAULT_NONE,
    FAULT_DUP,
    FAULT_PLUS,
    FAULT_MINUS,
    FAULT_LEN
  } alpha_fault_t;

  // expected text of every accepted request, in output order
  class radix_text_board;
    logic [RADIX_LEN_W-1:0] radix_len = '0;
    logic [CFG_DATA_W-1:0]  digits_lo = '0;
    logic [CFG_DATA_W-1:0]  digits_hi = '0;
    text_char_t             pending_text[$];
    int                     mismatches = 0;

    function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        srta_pkg::REG_RADIX_LEN:   radix_len = data[RADIX_LEN_W-1:0];
        srta_pkg::REG_DIGITS_LOW:  digits_lo = data;
        srta_pkg::REG_DIGITS_HIGH: digits_hi = data;
        default: ;
      endcase
    endfunction

    // spell one accepted value in the current alphabet
    function void spell_value(logic [IN_DATA_W-1:0] v);
      logic [CHAR_W-1:0] glyph [ALPHA_CHARS];
      logic [IN_DATA_W:0] mag;
      logic [IN_DATA_W:0] base;
      int unsigned        digit_q[$];
      int                 n;
      int                 i;
      int                 j;
      bit                 ok;
      n = int'(radix_len);
      for (i = 0; i < ALPHA_CHARS; i++)
        glyph[i] = (i < 8) ? digits_lo[8*i +: 8] : digits_hi[8*(i-8) +: 8];
      // alphabet length must be in range, characters unique and free of sign characters
      ok = (n >= 2) && (n <= MAX_RADIX_DEF);
      for (i = 0; i < n && i < ALPHA_CHARS; i++) begin
        if (glyph[i] == srta_pkg::CH_PLUS || glyph[i] == srta_pkg::CH_MINUS) ok = 0;
        for (j = i + 1; j < n && j < ALPHA_CHARS; j++)
          if (glyph[j] == glyph[i]) ok = 0;
      end
      if (!ok) begin
        pending_text.push_back('{glyph: srta_pkg::CH_ZERO, last: 1'b1});
        return;
      end
      // magnitude in one extra bit so the most negative value stays exact
      mag  = v[IN_DATA_W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
      base = (IN_DATA_W+1)'(n);
      do begin
        digit_q.push_front(int'(mag % base));
        mag = mag / base;
      end while (mag != 0);
      if (v[IN_DATA_W-1])
        pending_text.push_back('{glyph: srta_pkg::CH_MINUS, last: 1'b0});
      for (i = 0; i < digit_q.size(); i++)
        pending_text.push_back('{glyph: glyph[digit_q[i]], last: i == digit_q.size() - 1});
    endfunction

    function void check_char(logic [CHAR_W-1:0] glyph, logic last);
      text_char_t want;
      if (pending_text.size() == 0) begin
        $display("%0t: char %h last %b with no pending request", $time, glyph, last);
        mismatches++;
        return;
      end
      want = pending_text.pop_front();
      if (glyph !== want.glyph) begin
        $display("%0t: char mismatch, expected %h got %h", $time, want.glyph, glyph);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch, expected %b got %b", $time, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [CHAR_W-1:0]      m_tdata;
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  radix_text_board board = new();
  bit              gaps_on = 1'b1;
  int              stall_left = 0;
  int              idle_cycles = 0;

  signed_radix_to_ascii_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // value
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // out_char
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // output side: check characters, stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) board.check_char(m_tdata, m_tlast);
      if (stall_left != 0) stall_left = stall_left - 1;
      else if (gaps_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 7);
      m_tready <= (stall_left == 0);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request, with an optional idle burst before it
  task automatic send_value(input logic [IN_DATA_W-1:0] v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    board.spell_value(v);
  endtask

  // stop sending and let every pending character come out
  task automatic drain_text();
    s_tvalid <= 1'b0;
    while (board.pending_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers on consecutive edges
  task automatic load_alphabet(input logic [RADIX_LEN_W-1:0] n,
                               input logic [CFG_DATA_W-1:0] lo,
                               input logic [CFG_DATA_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= srta_pkg::REG_RADIX_LEN;
    cfg_data  <= CFG_DATA_W'(n);
    @(posedge clk);
    board.set_reg(srta_pkg::REG_RADIX_LEN, CFG_DATA_W'(n));
    cfg_index <= srta_pkg::REG_DIGITS_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    board.set_reg(srta_pkg::REG_DIGITS_LOW, lo);
    cfg_index <= srta_pkg::REG_DIGITS_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    board.set_reg(srta_pkg::REG_DIGITS_HIGH, hi);
    cfg_we <= 1'b0;
  endtask

  // random alphabet: distinct legal characters in use, garbage beyond, then the chosen fault
  task automatic pick_alphabet(input int n, input alpha_fault_t fault,
                               output logic [CFG_DATA_W-1:0] lo,
                               output logic [CFG_DATA_W-1:0] hi);
    logic [2*CFG_DATA_W-1:0] pack;
    logic [CHAR_W-1:0]       c;
    bit                      clash;
    int                      i;
    int                      j;
    pack = {$urandom, $urandom, $urandom, $urandom};
    for (i = 0; i < n; i++) begin
      do begin
        c = CHAR_W'($urandom_range(0, 255));
        clash = (c == srta_pkg::CH_PLUS) || (c == srta_pkg::CH_MINUS);
        for (j = 0; j < i; j++)
          if (pack[8*j +: 8] == c) clash = 1;
      end while (clash);
      pack[8*i +: 8] = c;
    end
    case (fault)
      FAULT_DUP: begin
        i = $urandom_range(0, n - 2);
        j = $urandom_range(i + 1, n - 1);
        pack[8*j +: 8] = pack[8*i +: 8];
      end
      FAULT_PLUS:  pack[8*$urandom_range(0, n - 1) +: 8] = srta_pkg::CH_PLUS;
      FAULT_MINUS: pack[8*$urandom_range(0, n - 1) +: 8] = srta_pkg::CH_MINUS;
      default: ;
    endcase
    lo = pack[CFG_DATA_W-1:0];
    hi = pack[2*CFG_DATA_W-1:CFG_DATA_W];
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [IN_DATA_W-1:0]  v;
    alpha_fault_t          fault;
    int                    n;
    int                    phase;
    int                    k;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers still at reset: empty alphabet
    send_value(32'h0000_0000);
    send_value(32'hFFFF_FFFF);
    drain_text();

    // binary, including the longest text
    load_alphabet(5'd2, 64'("10"), 64'h0);
    send_value(32'h0000_0000);
    send_value(32'h0000_0001);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    drain_text();

    // hex
    load_alphabet(5'd16, 64'("76543210"), 64'("FEDCBA98"));
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'hFFFF_FFF0);
    send_value(32'h0000_00FF);
    drain_text();

    // decimal
    load_alphabet(5'd10, 64'("76543210"), 64'("98"));
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'hFFFF_FFF6);
    send_value(32'h0000_0009);
    drain_text();

    // zero byte as the digit of value zero
    load_alphabet(5'd16, {56'("7654321"), 8'h00}, 64'("FEDCBA98"));
    send_value(32'h0000_0000);
    send_value(32'hFFFF_FFEF);
    drain_text();

    // sign characters past the used part are harmless
    load_alphabet(5'd2, 64'("++10"), 64'("--------"));
    send_value(32'h0000_0003);
    drain_text();

    // broken alphabets: too short, repeated, plus, minus at the top
    load_alphabet(5'd1, 64'("10"), 64'h0);
    send_value(32'h0000_0005);
    drain_text();
    load_alphabet(5'd3, 64'("aba"), 64'h0);
    send_value(32'h0000_0007);
    drain_text();
    load_alphabet(5'd4, 64'("3+10"), 64'h0);
    send_value(32'hFFFF_FFFE);
    drain_text();
    load_alphabet(5'd16, 64'("76543210"), 64'("-EDCBA98"));
    send_value(32'h0000_0010);
    drain_text();

    // random alphabets and values; quiet handshakes at the end
    for (phase = 0; phase < PHASES; phase++) begin
      gaps_on = (phase < PHASES - 2);
      fault = FAULT_NONE;
      case (phase)
        0: n = 2;
        1: n = MAX_RADIX_DEF;
        default: n = $urandom_range(2, MAX_RADIX_DEF);
      endcase
      if (phase >= 2 && $urandom_range(0, 5) == 0)
        fault = alpha_fault_t'($urandom_range(FAULT_DUP, FAULT_LEN));
      if (fault == FAULT_LEN) n = $urandom_range(0, 1);
      pick_alphabet(n, fault, lo, hi);
      load_alphabet(RADIX_LEN_W'(n), lo, hi);
      for (k = 0; k < PHASE_VALUES; k++) begin
        case ($urandom_range(0, 9))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = IN_DATA_W'($urandom_range(0, 40) - 20);
          3: v = IN_DATA_W'($urandom_range(0, 1)) - 1'b1;
          default: v = $urandom;
        endcase
        send_value(v);
      end
      drain_text();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending_text.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/srta_pkg.sv
rtl/srta_div.sv
rtl/srta_stack.sv
rtl/srta_check.sv
rtl/signed_radix_to_ascii_unit.sv
tb/tb.sv
